FILE: rtl/mlbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the multi-LED blink controller.
package mlbc_pkg;

    // Widths fixed by the request and result fields
    localparam int FUNC_W   = 2;
    localparam int MASK_W   = 4;
    localparam int MODE_W   = 3;
    localparam int LED_W    = 4;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PERIOD_DEFAULT = 2'd0,
        CFG_PERIOD_SLOW    = 2'd1,
        CFG_PERIOD_FAST    = 2'd2
    } cfg_addr_t;

    localparam logic [CFG_DATA_W-1:0] PERIOD_DEFAULT_RST = 16'd500;
    localparam logic [CFG_DATA_W-1:0] PERIOD_SLOW_RST    = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] PERIOD_FAST_RST    = 16'd200;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_SET_MODE = 2'd1,
        FUNC_TOGGLE   = 2'd2
    } func_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF         = 3'd0,
        MODE_ON          = 3'd1,
        MODE_BLINK       = 3'd2,
        MODE_BLINK_SLOW  = 3'd3,
        MODE_BLINK_FAST  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_MASK = 2'd1,
        STATUS_BAD_MODE = 2'd2
    } status_t;

endpackage

FILE: rtl/multi_led_blink_controller_top.sv
`timescale 1ns / 1ps
// Multi-LED blink controller: takes one tick or command per cycle while no
// stalled result holds s_ready low, and drives NUM_LEDS LED levels. At
// acceptance the per-LED countdowns, levels and blink flags update in parallel,
// and the result (levels and blink flags of LEDs 0..3 plus a status) lands in
// an output register in the cycle after. The output register decouples the two
// sides, so s_ready stays high while the result is taken in the same cycle:
// a sustained rate of one request per clock. The user must write the period
// registers via cfg_wen/cfg_addr/cfg_wdata while idle; nothing enforces it.
module multi_led_blink_controller_top #(
    parameter int NUM_LEDS    = 4,
    parameter int PERIOD_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wen,
    input  logic [mlbc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mlbc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mlbc_pkg::FUNC_W-1:0]         s_func,
    input  logic [mlbc_pkg::MASK_W-1:0]         s_led_mask,
    input  logic [mlbc_pkg::MODE_W-1:0]         s_mode,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mlbc_pkg::LED_W-1:0]          m_led_levels,
    output logic [mlbc_pkg::LED_W-1:0]          m_blinking_mask,
    output logic [mlbc_pkg::STATUS_W-1:0]       m_status
);

    localparam int OUT_W  = mlbc_pkg::LED_W;
    localparam logic [PERIOD_BITS-1:0] CNT_ONE = PERIOD_BITS'(1);

    // configuration registers
    logic [mlbc_pkg::CFG_DATA_W-1:0] period_default_reg;
    logic [mlbc_pkg::CFG_DATA_W-1:0] period_slow_reg;
    logic [mlbc_pkg::CFG_DATA_W-1:0] period_fast_reg;

    // per-LED state
    logic [NUM_LEDS-1:0]    level_reg, level_next;
    logic [NUM_LEDS-1:0]    blink_on_reg, blink_on_next;
    logic [PERIOD_BITS-1:0] countdown_reg [NUM_LEDS];
    logic [PERIOD_BITS-1:0] countdown_next [NUM_LEDS];
    logic [PERIOD_BITS-1:0] period_reg [NUM_LEDS];
    logic [PERIOD_BITS-1:0] period_next [NUM_LEDS];

    // result register
    logic                             m_valid_reg;
    logic [OUT_W-1:0]                 led_levels_reg;
    logic [OUT_W-1:0]                 blinking_mask_reg;
    mlbc_pkg::status_t                status_reg, status_next;

    logic                   s_accept;
    logic [NUM_LEDS-1:0]    mask_ext;
    logic                   mask_ok;
    logic [PERIOD_BITS-1:0] sel_period;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // an empty mask or mask bits at or above NUM_LEDS make the command invalid
    assign mask_ext = NUM_LEDS'(s_led_mask);
    assign mask_ok  = (s_led_mask != '0) &&
                      ((32'(s_led_mask) >> NUM_LEDS) == 32'd0);

    always_comb begin
        case (s_mode)
            mlbc_pkg::MODE_BLINK_SLOW: sel_period = PERIOD_BITS'(period_slow_reg);
            mlbc_pkg::MODE_BLINK_FAST: sel_period = PERIOD_BITS'(period_fast_reg);
            default:                   sel_period = PERIOD_BITS'(period_default_reg);
        endcase
    end

    always_comb begin
        level_next    = level_reg;
        blink_on_next = blink_on_reg;
        status_next   = mlbc_pkg::STATUS_OK;
        for (int i = 0; i < NUM_LEDS; i++) begin
            countdown_next[i] = countdown_reg[i];
            period_next[i]    = period_reg[i];
        end
        case (s_func)
            mlbc_pkg::FUNC_TICK: begin
                for (int i = 0; i < NUM_LEDS; i++) begin
                    if (blink_on_reg[i]) begin
                        if (countdown_reg[i] <= CNT_ONE) begin
                            level_next[i]     = !level_reg[i];
                            countdown_next[i] = period_reg[i];
                        end else begin
                            countdown_next[i] = countdown_reg[i] - CNT_ONE;
                        end
                    end
                end
            end
            mlbc_pkg::FUNC_TOGGLE: begin
                if (!mask_ok) begin
                    status_next = mlbc_pkg::STATUS_BAD_MASK;
                end else begin
                    blink_on_next = blink_on_reg & ~mask_ext;
                    level_next    = level_reg ^ mask_ext;
                end
            end
            mlbc_pkg::FUNC_SET_MODE: begin
                if (!mask_ok) begin
                    status_next = mlbc_pkg::STATUS_BAD_MASK;
                end else begin
                    case (s_mode)
                        mlbc_pkg::MODE_OFF: begin
                            blink_on_next = blink_on_reg & ~mask_ext;
                            level_next    = level_reg & ~mask_ext;
                        end
                        mlbc_pkg::MODE_ON: begin
                            blink_on_next = blink_on_reg & ~mask_ext;
                            level_next    = level_reg | mask_ext;
                        end
                        mlbc_pkg::MODE_BLINK,
                        mlbc_pkg::MODE_BLINK_SLOW,
                        mlbc_pkg::MODE_BLINK_FAST: begin
                            // keep the level, arm the period
                            blink_on_next = blink_on_reg | mask_ext;
                            for (int i = 0; i < NUM_LEDS; i++) begin
                                if (mask_ext[i]) begin
                                    countdown_next[i] = sel_period;
                                    period_next[i]    = sel_period;
                                end
                            end
                        end
                        default: status_next = mlbc_pkg::STATUS_BAD_MODE;
                    endcase
                end
            end
            default: status_next = mlbc_pkg::STATUS_BAD_MODE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_default_reg <= mlbc_pkg::PERIOD_DEFAULT_RST;
            period_slow_reg    <= mlbc_pkg::PERIOD_SLOW_RST;
            period_fast_reg    <= mlbc_pkg::PERIOD_FAST_RST;
        end else if (cfg_wen) begin
            case (cfg_addr)
                mlbc_pkg::CFG_PERIOD_DEFAULT: period_default_reg <= cfg_wdata;
                mlbc_pkg::CFG_PERIOD_SLOW:    period_slow_reg    <= cfg_wdata;
                mlbc_pkg::CFG_PERIOD_FAST:    period_fast_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= '0;
            blink_on_reg <= '0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                countdown_reg[i] <= '0;
                period_reg[i]    <= '0;
            end
        end else if (s_accept) begin
            level_reg    <= level_next;
            blink_on_reg <= blink_on_next;
            for (int i = 0; i < NUM_LEDS; i++) begin
                countdown_reg[i] <= countdown_next[i];
                period_reg[i]    <= period_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload: load on every accepted request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            led_levels_reg    <= OUT_W'(level_next);
            blinking_mask_reg <= OUT_W'(blink_on_next);
            status_reg        <= status_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_led_levels    = led_levels_reg;
    assign m_blinking_mask = blinking_mask_reg;
    assign m_status        = status_reg;

endmodule

FILE: rtl/mlbc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the multi-LED blink controller, with its bind.
module mlbc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [mlbc_pkg::FUNC_W-1:0]       s_func,
    input logic [mlbc_pkg::MASK_W-1:0]       s_led_mask,
    input logic [mlbc_pkg::MODE_W-1:0]       s_mode,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [mlbc_pkg::LED_W-1:0]        m_led_levels,
    input logic [mlbc_pkg::LED_W-1:0]        m_blinking_mask,
    input logic [mlbc_pkg::STATUS_W-1:0]     m_status
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_levels) &&
        $stable(m_blinking_mask) && $stable(m_status))
        else $error("result changed while stalled");

    // an empty output register always takes a request
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request blocked with empty output register");

    // a tick shows up next cycle with status ok
    a_tick_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == mlbc_pkg::FUNC_TICK |=>
        m_valid && m_status == mlbc_pkg::STATUS_OK)
        else $error("tick result missing or not ok");

    // forcing LED 0 off clears its level and blink flag
    a_led0_off: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == mlbc_pkg::FUNC_SET_MODE &&
        s_mode == mlbc_pkg::MODE_OFF && s_led_mask == 4'b0001 |=>
        m_valid && !m_led_levels[0] && !m_blinking_mask[0] &&
        m_status == mlbc_pkg::STATUS_OK)
        else $error("LED 0 not forced off");

endmodule

bind multi_led_blink_controller_top mlbc_checker u_mlbc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_func          (s_func),
    .s_led_mask      (s_led_mask),
    .s_mode          (s_mode),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_led_levels    (m_led_levels),
    .m_blinking_mask (m_blinking_mask),
    .m_status        (m_status)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-LED blink controller: directed and random requests.
module testbench;

    localparam int NUM_LEDS = 4;
    localparam int PERIOD_BITS = 16;
    localparam logic [mlbc_pkg::FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [mlbc_pkg::LED_W-1:0]    levels;
        logic [mlbc_pkg::LED_W-1:0]    blinking;
        logic [mlbc_pkg::STATUS_W-1:0] status;
    } led_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wen = 1'b0;
    logic [mlbc_pkg::CFG_ADDR_W-1:0] cfg_addr = mlbc_pkg::CFG_PERIOD_DEFAULT;
    logic [mlbc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [mlbc_pkg::FUNC_W-1:0]     s_func = mlbc_pkg::FUNC_TICK;
    logic [mlbc_pkg::MASK_W-1:0]     s_led_mask = '0;
    logic [mlbc_pkg::MODE_W-1:0]     s_mode = mlbc_pkg::MODE_OFF;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [mlbc_pkg::LED_W-1:0]      m_led_levels;
    logic [mlbc_pkg::LED_W-1:0]      m_blinking_mask;
    logic [mlbc_pkg::STATUS_W-1:0]   m_status;

    // Predicted LED state and period registers
    logic [NUM_LEDS-1:0]             led_level;
    logic [NUM_LEDS-1:0]             led_blink;
    logic [PERIOD_BITS-1:0]          led_count [NUM_LEDS];
    logic [PERIOD_BITS-1:0]          led_reload [NUM_LEDS];
    logic [mlbc_pkg::CFG_DATA_W-1:0] period_default, period_slow, period_fast;

    led_result_t expected_results [$];
    int mismatch_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    multi_led_blink_controller_top #(
        .NUM_LEDS(NUM_LEDS),
        .PERIOD_BITS(PERIOD_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wen(cfg_wen),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_led_mask(s_led_mask),
        .s_mode(s_mode),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_led_levels(m_led_levels),
        .m_blinking_mask(m_blinking_mask),
        .m_status(m_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_results
        led_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: levels %h blinking %h status %0d",
                       m_led_levels, m_blinking_mask, m_status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_led_levels !== want.levels) begin
                    $error("led_levels: expected %h, got %h", want.levels, m_led_levels);
                    mismatch_count++;
                end
                if (m_blinking_mask !== want.blinking) begin
                    $error("blinking_mask: expected %h, got %h", want.blinking, m_blinking_mask);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void predict_led_state(input logic [mlbc_pkg::FUNC_W-1:0] func,
                                              input logic [mlbc_pkg::MASK_W-1:0] mask,
                                              input logic [mlbc_pkg::MODE_W-1:0] mode);
        logic [PERIOD_BITS-1:0]        period;
        logic [mlbc_pkg::STATUS_W-1:0] status;
        status = mlbc_pkg::STATUS_OK;
        period = '0;
        if (func == mlbc_pkg::FUNC_TICK) begin
            for (int i = 0; i < NUM_LEDS; i++) begin
                if (led_blink[i]) begin
                    // a count of zero or one runs out on this tick
                    if (led_count[i] <= 1) begin
                        led_level[i] = ~led_level[i];
                        led_count[i] = led_reload[i];
                    end else begin
                        led_count[i] = led_count[i] - 1'b1;
                    end
                end
            end
        end else if (func == FUNC_UNKNOWN) begin
            status = mlbc_pkg::STATUS_BAD_MODE;
        end else if (mask == '0 || (mask >> NUM_LEDS) != '0) begin
            status = mlbc_pkg::STATUS_BAD_MASK;
        end else if (func == mlbc_pkg::FUNC_TOGGLE) begin
            led_blink &= ~mask;
            led_level ^= mask;
        end else if (mode > mlbc_pkg::MODE_BLINK_FAST) begin
            status = mlbc_pkg::STATUS_BAD_MODE;
        end else if (mode == mlbc_pkg::MODE_OFF) begin
            led_blink &= ~mask;
            led_level &= ~mask;
        end else if (mode == mlbc_pkg::MODE_ON) begin
            led_blink &= ~mask;
            led_level |= mask;
        end else begin
            case (mode)
                mlbc_pkg::MODE_BLINK:      period = period_default;
                mlbc_pkg::MODE_BLINK_SLOW: period = period_slow;
                default:                   period = period_fast;
            endcase
            for (int i = 0; i < NUM_LEDS; i++) begin
                if (mask[i]) begin
                    led_blink[i] = 1'b1;
                    led_reload[i] = period;
                    led_count[i] = period;
                end
            end
        end
        expected_results.push_back('{led_level, led_blink, status});
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with s_valid still high.
    task automatic send_request(input logic [mlbc_pkg::FUNC_W-1:0] func,
                                input logic [mlbc_pkg::MASK_W-1:0] mask,
                                input logic [mlbc_pkg::MODE_W-1:0] mode);
        if ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_gap_pct);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_led_mask <= mask;
        s_mode <= mode;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_led_state(func, mask, mode);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_periods(input logic [mlbc_pkg::CFG_DATA_W-1:0] pd,
                                input logic [mlbc_pkg::CFG_DATA_W-1:0] ps,
                                input logic [mlbc_pkg::CFG_DATA_W-1:0] pf);
        cfg_wen <= 1'b1;
        cfg_addr <= mlbc_pkg::CFG_PERIOD_DEFAULT;
        cfg_wdata <= pd;
        @(negedge aclk);
        cfg_addr <= mlbc_pkg::CFG_PERIOD_SLOW;
        cfg_wdata <= ps;
        @(negedge aclk);
        cfg_addr <= mlbc_pkg::CFG_PERIOD_FAST;
        cfg_wdata <= pf;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        period_default = pd;
        period_slow = ps;
        period_fast = pf;
    endtask

    task automatic apply_reset();
        led_level = '0;
        led_blink = '0;
        for (int i = 0; i < NUM_LEDS; i++) begin
            led_count[i] = '0;
            led_reload[i] = '0;
        end
        period_default = mlbc_pkg::PERIOD_DEFAULT_RST;
        period_slow = mlbc_pkg::PERIOD_SLOW_RST;
        period_fast = mlbc_pkg::PERIOD_FAST_RST;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
    endtask

    task automatic test_commands_and_errors();
        send_request(mlbc_pkg::FUNC_TICK, 4'hF, 3'h7);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'hF, mlbc_pkg::MODE_ON);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h5, mlbc_pkg::MODE_OFF);
        send_request(mlbc_pkg::FUNC_TOGGLE, 4'hA, 3'h7);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h0, mlbc_pkg::MODE_ON);
        send_request(mlbc_pkg::FUNC_TOGGLE, 4'h0, mlbc_pkg::MODE_OFF);
        for (int m = mlbc_pkg::MODE_BLINK_FAST + 1; m < 2 ** mlbc_pkg::MODE_W; m++) begin
            send_request(mlbc_pkg::FUNC_SET_MODE, 4'h3, mlbc_pkg::MODE_W'(m));
        end
        // bad mask wins over bad mode
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h0, 3'h7);
        send_request(FUNC_UNKNOWN, 4'hF, mlbc_pkg::MODE_ON);
        send_request(FUNC_UNKNOWN, 4'h0, 3'h7);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h1, mlbc_pkg::MODE_BLINK);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h2, mlbc_pkg::MODE_BLINK_SLOW);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'hC, mlbc_pkg::MODE_BLINK_FAST);
        send_request(mlbc_pkg::FUNC_TICK, 4'h0, mlbc_pkg::MODE_OFF);
        send_request(mlbc_pkg::FUNC_TICK, 4'h5, 3'h5);
        send_request(mlbc_pkg::FUNC_TOGGLE, 4'h4, mlbc_pkg::MODE_BLINK);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h8, mlbc_pkg::MODE_ON);
        send_request(mlbc_pkg::FUNC_TICK, 4'hF, mlbc_pkg::MODE_OFF);
        drain_results();
    endtask

    task automatic test_period_extremes();
        load_periods(16'd0, 16'd1, 16'hFFFF);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h1, mlbc_pkg::MODE_BLINK);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h2, mlbc_pkg::MODE_BLINK_SLOW);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'h4, mlbc_pkg::MODE_BLINK_FAST);
        repeat (4) send_request(mlbc_pkg::FUNC_TICK, 4'h0, mlbc_pkg::MODE_OFF);
        drain_results();
        load_periods(16'd2, 16'd3, 16'd1);
        send_request(mlbc_pkg::FUNC_SET_MODE, 4'hF, mlbc_pkg::MODE_BLINK_SLOW);
        repeat (7) send_request(mlbc_pkg::FUNC_TICK, 4'hF, 3'h7);
        drain_results();
    endtask

    task automatic send_random_request();
        logic [mlbc_pkg::FUNC_W-1:0] func;
        logic [mlbc_pkg::MASK_W-1:0] mask;
        logic [mlbc_pkg::MODE_W-1:0] mode;
        int pick;
        pick = $urandom_range(99);
        func = mlbc_pkg::FUNC_TICK;
        mask = mlbc_pkg::MASK_W'($urandom_range(15, 1));
        mode = mlbc_pkg::MODE_W'($urandom);
        if (pick < 50) begin
            func = mlbc_pkg::FUNC_TICK;
        end else if (pick < 75) begin
            func = mlbc_pkg::FUNC_SET_MODE;
            mode = mlbc_pkg::MODE_W'($urandom_range(mlbc_pkg::MODE_BLINK_FAST));
        end else if (pick < 87) begin
            func = mlbc_pkg::FUNC_TOGGLE;
        end else begin
            func = mlbc_pkg::FUNC_W'($urandom);
            mask = mlbc_pkg::MASK_W'($urandom);
            mode = mlbc_pkg::MODE_W'($urandom);
        end
        send_request(func, mask, mode);
    endtask

    task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct,
                                       input logic [mlbc_pkg::CFG_DATA_W-1:0] pd,
                                       input logic [mlbc_pkg::CFG_DATA_W-1:0] ps,
                                       input logic [mlbc_pkg::CFG_DATA_W-1:0] pf);
        load_periods(pd, ps, pf);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_request();
        drain_results();
    endtask

    initial begin
        apply_reset();
        test_commands_and_errors();
        test_period_extremes();
        test_random_traffic(500, 6, 55,
                            mlbc_pkg::CFG_DATA_W'($urandom_range(4, 1)),
                            mlbc_pkg::CFG_DATA_W'($urandom_range(8, 2)),
                            mlbc_pkg::CFG_DATA_W'($urandom_range(1)));
        test_random_traffic(500, 55, 6, 16'd0, 16'd3, 16'd7);
        test_random_traffic(500, 0, 0,
                            mlbc_pkg::CFG_DATA_W'($urandom_range(6, 1)),
                            mlbc_pkg::CFG_DATA_W'($urandom_range(12, 1)),
                            mlbc_pkg::CFG_DATA_W'($urandom_range(3, 1)));
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
